// ----- design/sdtw_pkg.sv -----
// shared types and constants for the signed decimal text writer
`timescale 1ns / 1ps
package sdtw_pkg;

   localparam int MAG_W         = 32;
   localparam int BCD_DIGITS    = 10;
   localparam int BCD_W         = 4 * BCD_DIGITS;
   localparam int DIGIT_CNT_W   = $clog2(BCD_DIGITS + 1);
   localparam int STEP_W        = $clog2(MAG_W);
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [7:0] ROW_LINE1 = 8'd1;
   localparam logic [7:0] ROW_LINE2 = 8'd2;
   localparam logic [7:0] ROW_LINE3 = 8'd3;
   localparam logic [7:0] ROW_LINE4 = 8'd4;

   localparam logic [7:0] BASE_LINE1 = 8'h80;
   localparam logic [7:0] BASE_LINE2 = 8'h90;
   localparam logic [7:0] BASE_LINE3 = 8'h88;
   localparam logic [7:0] BASE_LINE4 = 8'h98;

   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef struct packed {
      logic [7:0]       addr;
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_EMIT_ADDR,
      BACK_EMIT_SIGN,
      BACK_EMIT_DIGITS
   } back_state_type;

endpackage

// ----- design/signed_decimal_text_writer.sv -----
// top level of the signed decimal text writer
//
//   channel   ports                                 handshake
//   request   req_row, req_column, req_value        start high while busy low
//   response  rsp_is_data, rsp_byte_value, rsp_last rsp_strobe, once per beat
//
// the back end handles one number at a time: one fetch from the queue,
// 32 shift-add-3 steps, then one beat per cycle for address, sign and digits
// the front end keeps taking requests until the queue is full, busy follows it
// synchronous reset empties the queue and returns the sequencer to idle
// the receiver cannot stall, every beat is taken in its cycle
`timescale 1ns / 1ps
module signed_decimal_text_writer #(
   parameter int QUEUE_DEPTH = sdtw_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_row,
   input  logic [7:0]         req_column,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic               rsp_is_data,
   output logic [7:0]         rsp_byte_value,
   output logic               rsp_last
);
   import sdtw_pkg::*;

   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type status;

   assign busy = status.full;

   sdtw_front u_front (
      .start      (start),
      .queue_full (status.full),
      .req_row    (req_row),
      .req_column (req_column),
      .req_value  (req_value),
      .push       (push),
      .entry      (push_entry)
   );

   sdtw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   sdtw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .status         (status),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_is_data    (rsp_is_data),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- design/sdtw_front.sv -----
// front end: accepts requests and forms cursor address, sign and magnitude
`timescale 1ns / 1ps
module sdtw_front (
   input  logic                      start,
   input  logic                      queue_full,
   input  logic [7:0]                req_row,
   input  logic [7:0]                req_column,
   input  logic signed [31:0]        req_value,
   output logic                      push,
   output sdtw_pkg::entry_type       entry
);
   import sdtw_pkg::*;

   logic [7:0]       base;
   logic [MAG_W-1:0] raw;

   always_comb begin
      case (req_row)
         ROW_LINE1: base = BASE_LINE1;
         ROW_LINE2: base = BASE_LINE2;
         ROW_LINE3: base = BASE_LINE3;
         ROW_LINE4: base = BASE_LINE4;
         default:   base = req_row;
      endcase
   end

   assign raw  = MAG_W'(req_value);
   assign push = start && !queue_full;

   always_comb begin
      entry.addr      = base + req_column;
      entry.negative  = raw[MAG_W-1];
      entry.magnitude = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
   end

endmodule

// ----- design/sdtw_queue.sv -----
// short queue of classified requests between front and back
`timescale 1ns / 1ps
module sdtw_queue #(
   parameter int DEPTH = sdtw_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sdtw_pkg::entry_type        push_entry,
   input  logic                       pop,
   output sdtw_pkg::entry_type        head,
   output sdtw_pkg::queue_status_type status
);
   import sdtw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entries_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/sdtw_back.sv -----
// back end: shift-add-3 conversion and byte sequencer
`timescale 1ns / 1ps
module sdtw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sdtw_pkg::entry_type        head,
   input  sdtw_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic                       rsp_is_data,
   output logic [7:0]                 rsp_byte_value,
   output logic                       rsp_last
);
   import sdtw_pkg::*;

   back_state_type         state_ff, state_in;
   logic [7:0]             addr_ff, addr_in;
   logic                   neg_ff, neg_in;
   logic [MAG_W-1:0]       bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DIGIT_CNT_W-1:0] left_ff, left_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [DIGIT_CNT_W-1:0] num_digits;
   logic [DIGIT_CNT_W+1:0] lead_shift;

   function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] b);
      logic [BCD_W-1:0] r;
      r = b;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (b[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = b[4*i +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

   function automatic logic [DIGIT_CNT_W-1:0] count_digits(input logic [BCD_W-1:0] b);
      logic [DIGIT_CNT_W-1:0] n;
      n = DIGIT_CNT_W'(1);
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (b[4*i +: 4] != 4'd0) begin
            n = DIGIT_CNT_W'(i + 1);
         end
      end
      return n;
   endfunction

   assign bcd_adj    = add3(bcd_ff);
   assign num_digits = count_digits(bcd_ff);
   assign lead_shift = {DIGIT_CNT_W'(BCD_DIGITS) - num_digits, 2'b00};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!status.empty) state_in = BACK_CONVERT;
         end
         BACK_CONVERT: begin
            if (step_ff == STEP_W'(MAG_W - 1)) state_in = BACK_EMIT_ADDR;
         end
         BACK_EMIT_ADDR: begin
            state_in = neg_ff ? BACK_EMIT_SIGN : BACK_EMIT_DIGITS;
         end
         BACK_EMIT_SIGN: begin
            state_in = BACK_EMIT_DIGITS;
         end
         BACK_EMIT_DIGITS: begin
            if (left_ff == DIGIT_CNT_W'(1)) state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop            = 1'b0;
      rsp_strobe     = 1'b0;
      rsp_is_data    = 1'b0;
      rsp_byte_value = '0;
      rsp_last       = 1'b0;
      addr_in        = addr_ff;
      neg_in         = neg_ff;
      bin_in         = bin_ff;
      bcd_in         = bcd_ff;
      step_in        = step_ff;
      left_in        = left_ff;
      case (state_ff)
         BACK_IDLE: begin
            pop     = !status.empty;
            addr_in = head.addr;
            neg_in  = head.negative;
            bin_in  = head.magnitude;
            bcd_in  = '0;
            step_in = '0;
         end
         BACK_CONVERT: begin
            bcd_in  = {bcd_adj[BCD_W-2:0], bin_ff[MAG_W-1]};
            bin_in  = {bin_ff[MAG_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
         end
         BACK_EMIT_ADDR: begin
            rsp_strobe     = 1'b1;
            rsp_byte_value = addr_ff;
            left_in        = num_digits;
            bcd_in         = bcd_ff << lead_shift;
         end
         BACK_EMIT_SIGN: begin
            rsp_strobe     = 1'b1;
            rsp_is_data    = 1'b1;
            rsp_byte_value = CHAR_MINUS;
         end
         BACK_EMIT_DIGITS: begin
            rsp_strobe     = 1'b1;
            rsp_is_data    = 1'b1;
            rsp_byte_value = CHAR_ZERO | {4'b0000, bcd_ff[BCD_W-1 -: 4]};
            rsp_last       = (left_ff == DIGIT_CNT_W'(1));
            bcd_in         = {bcd_ff[BCD_W-5:0], 4'b0000};
            left_in        = left_ff - DIGIT_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      neg_ff  <= neg_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      left_ff <= left_in;
   end

endmodule

// ----- design/sdtw_checker.sv -----
// port-level checker for the signed decimal text writer, with its bind
`timescale 1ns / 1ps
module sdtw_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_is_data,
   input logic [7:0] rsp_byte_value,
   input logic       rsp_last
);
   import sdtw_pkg::*;

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !busy && !rsp_strobe)
      else $error("busy or strobe right after reset");

   a_cmd_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_data |-> !rsp_last)
      else $error("address beat marked last");

   a_cmd_then_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_data |=> rsp_strobe && rsp_is_data)
      else $error("address beat not followed by data");

   a_sign_then_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_data && rsp_byte_value == CHAR_MINUS
      |=> rsp_strobe && rsp_is_data && rsp_byte_value != CHAR_MINUS)
      else $error("minus sign not followed by a digit");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("beat right after last");

endmodule

bind signed_decimal_text_writer sdtw_checker u_sdtw_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_is_data    (rsp_is_data),
   .rsp_byte_value (rsp_byte_value),
   .rsp_last       (rsp_last)
);

// ----- dv/tb_signed_decimal_text_writer.sv -----
// testbench for the signed decimal text writer: directed and random numbers in, display beats checked
`timescale 1ns / 1ps
module tb_signed_decimal_text_writer;
   import sdtw_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 450;

   typedef struct {
      logic       is_data;
      logic [7:0] byte_value;
      logic       last;
   } display_beat_type;

   class text_scoreboard;
      display_beat_type pending_text[$];
      int               failures;
      int               reported;

      function new();
         failures = 0;
         reported = 0;
      endfunction

      function void flag(string what);
         failures++;
         if (reported < 10) begin
            reported++;
            $display("%0t: %s", $realtime, what);
         end
      endfunction

      // expected beats for one accepted number
      function void note_number(logic [7:0] row, logic [7:0] column, logic [31:0] value);
         logic [7:0]       base;
         logic [31:0]      mag;
         logic [3:0]       digits[10];
         int               count;
         display_beat_type b;
         case (row)
            ROW_LINE1: base = BASE_LINE1;
            ROW_LINE2: base = BASE_LINE2;
            ROW_LINE3: base = BASE_LINE3;
            ROW_LINE4: base = BASE_LINE4;
            default:   base = row;
         endcase
         b.is_data    = 1'b0;
         b.byte_value = base + column;
         b.last       = 1'b0;
         pending_text.push_back(b);
         mag = value[31] ? -value : value;
         count = 0;
         do begin
            digits[count] = 4'(mag % 10);
            count++;
            mag = mag / 10;
         end while (mag != 0);
         if (value[31]) begin
            b.is_data    = 1'b1;
            b.byte_value = CHAR_MINUS;
            b.last       = 1'b0;
            pending_text.push_back(b);
         end
         for (int i = count - 1; i >= 0; i--) begin
            b.is_data    = 1'b1;
            b.byte_value = CHAR_ZERO + digits[i];
            b.last       = (i == 0);
            pending_text.push_back(b);
         end
      endfunction

      function void check_beat(logic is_data, logic [7:0] byte_value, logic last);
         display_beat_type want;
         if (pending_text.size() == 0) begin
            flag($sformatf("unexpected beat is_data=%b byte=%h last=%b",
                           is_data, byte_value, last));
            return;
         end
         want = pending_text.pop_front();
         if (want.is_data !== is_data || want.byte_value !== byte_value
             || want.last !== last)
            flag($sformatf("beat mismatch: expected is_data=%b byte=%h last=%b, got %b %h %b",
                           want.is_data, want.byte_value, want.last,
                           is_data, byte_value, last));
      endfunction

      function void check_drained();
         if (pending_text.size() != 0)
            flag($sformatf("%0d expected beats never arrived", pending_text.size()));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [7:0]         req_row;
   logic [7:0]         req_column;
   logic signed [31:0] req_value;
   logic               rsp_strobe;
   logic               rsp_is_data;
   logic [7:0]         rsp_byte_value;
   logic               rsp_last;

   text_scoreboard text_board;
   int             cycle_count;
   bit             burst_mode;

   signed_decimal_text_writer DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_row        (req_row),
      .req_column     (req_column),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_is_data    (rsp_is_data),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last       (rsp_last)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            text_board.note_number(req_row, req_column, req_value);
         if (rsp_strobe)
            text_board.check_beat(rsp_is_data, rsp_byte_value, rsp_last);
      end
   end

   function automatic int pick_gap();
      int r;
      if (burst_mode)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      logic [31:0] decade;
      int          k;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 99);
         2: begin
            decade = 1;
            k = $urandom_range(0, 9);
            repeat (k) decade = decade * 10;
            v = $urandom_range(0, 1) ? decade : decade - 1;
         end
         3: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7fffffff;
               1: v = 32'h80000000;
               2: v = 32'h0;
               default: v = 32'hffffffff;
            endcase
         end
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 1))
         v = -v;
      return v;
   endfunction

   // hold start until the request is taken, then optionally drop it for a gap
   task automatic send_number(logic [7:0] row, logic [7:0] column, logic [31:0] value);
      int gap;
      req_row    <= row;
      req_column <= column;
      req_value  <= value;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [7:0] row;
      logic [7:0] column;
      text_board  = new();
      cycle_count = 0;
      burst_mode  = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_row     = '0;
      req_column  = '0;
      req_value   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_number(ROW_LINE1, 8'd0, 32'd0);
      send_number(ROW_LINE2, 8'd3, 32'd7);
      send_number(ROW_LINE3, 8'd15, -32'sd1);
      send_number(ROW_LINE4, 8'd255, 32'h7fffffff);
      send_number(8'd0, 8'd0, 32'h80000000);
      send_number(8'd255, 8'd255, 32'd9);
      send_number(8'd5, 8'd200, 32'd10);
      send_number(8'hff, 8'd1, -32'sd10);
      send_number(ROW_LINE1, 8'd255, 32'd999999999);
      send_number(ROW_LINE2, 8'd128, 32'd1000000000);
      send_number(ROW_LINE3, 8'd120, -32'sd1000000000);
      send_number(ROW_LINE4, 8'd104, -32'sd999999999);
      send_number(8'h80, 8'h80, 32'h55555555);
      send_number(8'haa, 8'h55, 32'haaaaaaaa);
      send_number(8'h55, 8'haa, -32'sd2147483647);
      send_number(ROW_LINE1, 8'd7, 32'd100);
      send_number(ROW_LINE2, 8'd1, -32'sd5);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0)
            burst_mode = ($urandom_range(0, 2) == 0);
         row = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(1, 4));
         case ($urandom_range(0, 7))
            0: column = 8'd0;
            1: column = 8'd255;
            default: column = 8'($urandom_range(0, 255));
         endcase
         send_number(row, column, pick_value());
      end
      start <= 1'b0;

      while (text_board.pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      text_board.check_drained();
      if (text_board.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
